@@ rtl/fome_pkg.sv @@
// Package with the constants and stage types of the fast order message encoder.
`default_nettype none
package fome_pkg;

  localparam logic [7:0] HdrPmap     = 8'hFC;
  localparam logic [7:0] HdrTemplate = 8'h81;
  localparam logic [7:0] HdrExponent = 8'h80;
  localparam logic [7:0] HdrPrice    = 8'h81;
  localparam logic [7:0] StopBit     = 8'h80;
  localparam logic [7:0] GroupMask   = 8'h7F;
  localparam logic [7:0] SizeLead    = 8'h01;

  localparam int NumGroups = 5;
  localparam int SegBytes  = NumGroups + 1;
  localparam int MsgBytes  = 16;
  localparam int WordBytes = 8;

  typedef struct packed {
    logic                          size_two;
    logic [7:0]                    size_last;
    logic [NumGroups-1:0][7:0]     groups;
    logic [2:0]                    num_len;
    logic [7:0]                    kind_byte;
  } split_t;

  typedef struct packed {
    logic                          size_two;
    logic [7:0]                    size_last;
    logic [SegBytes-1:0][7:0]      seg;
  } seg_t;

endpackage
`default_nettype wire

@@ rtl/fome_split.sv @@
// First stage: cuts the order fields into stop-bit groups and counts the ID bytes.
`default_nettype none
module fome_split (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [7:0]       order_size_i,
  input  wire logic [31:0]      order_number_i,
  input  wire logic [1:0]       order_kind_i,
  output logic                  valid_o,
  output fome_pkg::split_t      data_o
);

  logic             valid_q;
  fome_pkg::split_t data_d, data_q;

  always_comb begin
    data_d.size_two  = order_size_i[7];
    data_d.size_last = fome_pkg::StopBit | (order_size_i & fome_pkg::GroupMask);
    for (int i = 0; i < fome_pkg::NumGroups; i++) begin
      data_d.groups[i] = {1'b0, 7'(order_number_i >> (7 * i))};
    end
    data_d.groups[0] = data_d.groups[0] | fome_pkg::StopBit;
    priority if (data_d.groups[4] != 8'h00) begin
      data_d.num_len = 3'd5;
    end else if (data_d.groups[3] != 8'h00) begin
      data_d.num_len = 3'd4;
    end else if (data_d.groups[2] != 8'h00) begin
      data_d.num_len = 3'd3;
    end else if (data_d.groups[1] != 8'h00) begin
      data_d.num_len = 3'd2;
    end else begin
      data_d.num_len = 3'd1;
    end
    data_d.kind_byte = fome_pkg::StopBit | {6'd0, order_kind_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

@@ rtl/fome_seg.sv @@
// Second stage: lines up the order ID bytes and the type byte into one segment.
`default_nettype none
module fome_seg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire fome_pkg::split_t data_i,
  output logic                  valid_o,
  output fome_pkg::seg_t        data_o
);

  logic           valid_q;
  fome_pkg::seg_t data_d, data_q;
  logic [2:0]     idx [fome_pkg::SegBytes];

  always_comb begin
    data_d.size_two  = data_i.size_two;
    data_d.size_last = data_i.size_last;
    for (int i = 0; i < fome_pkg::SegBytes; i++) begin
      idx[i] = data_i.num_len - 3'(i) - 3'd1;
      if (3'(i) < data_i.num_len) begin
        data_d.seg[i] = data_i.groups[idx[i]];
      end else if (3'(i) == data_i.num_len) begin
        data_d.seg[i] = data_i.kind_byte;
      end else begin
        data_d.seg[i] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

@@ rtl/fome_pack.sv @@
// Third stage: places the header, size bytes and segment into the two output words.
`default_nettype none
module fome_pack (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire fome_pkg::seg_t data_i,
  output logic                valid_o,
  output logic [63:0]         low_word_o,
  output logic [63:0]         high_word_o
);

  logic                                valid_q;
  logic [fome_pkg::MsgBytes-1:0][7:0]  msg_d, msg_q;

  always_comb begin
    msg_d    = '0;
    msg_d[0] = fome_pkg::HdrPmap;
    msg_d[1] = fome_pkg::HdrTemplate;
    msg_d[2] = fome_pkg::HdrExponent;
    msg_d[3] = fome_pkg::HdrPrice;
    if (data_i.size_two) begin
      msg_d[4] = fome_pkg::SizeLead;
      msg_d[5] = data_i.size_last;
      for (int i = 0; i < fome_pkg::SegBytes; i++) begin
        msg_d[6 + i] = data_i.seg[i];
      end
    end else begin
      msg_d[4] = data_i.size_last;
      for (int i = 0; i < fome_pkg::SegBytes; i++) begin
        msg_d[5 + i] = data_i.seg[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      msg_q <= msg_d;
    end
  end

  assign valid_o     = valid_q;
  assign low_word_o  = msg_q[fome_pkg::WordBytes-1:0];
  assign high_word_o = msg_q[fome_pkg::MsgBytes-1:fome_pkg::WordBytes];

endmodule
`default_nettype wire

@@ rtl/fast_order_message_encoder_unit.sv @@
// Top level of the fast order message encoder: three register stages and their flow control.
// An accepted input passes through the split, segment and pack registers before it is a valid result.
// Throughput is one order per cycle while the pipeline is not held; the three stages advance together.
// The whole pipeline holds when the output register is full and not taken.
// Reset clears the valid bit of every stage; data registers are not reset.
`default_nettype none
module fast_order_message_encoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  order_size_i,
  input  wire logic [31:0] order_number_i,
  input  wire logic [1:0]  order_kind_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      low_word_o,
  output logic [63:0]      high_word_o
);

  logic             advance;
  logic             split_valid;
  logic             seg_valid;
  fome_pkg::split_t split_data;
  fome_pkg::seg_t   seg_data;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  fome_split u_split (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .valid_i       (in_valid_i),
    .order_size_i  (order_size_i),
    .order_number_i(order_number_i),
    .order_kind_i  (order_kind_i),
    .valid_o       (split_valid),
    .data_o        (split_data)
  );

  fome_seg u_seg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .valid_i(split_valid),
    .data_i (split_data),
    .valid_o(seg_valid),
    .data_o (seg_data)
  );

  fome_pack u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .valid_i    (seg_valid),
    .data_i     (seg_data),
    .valid_o    (out_valid_o),
    .low_word_o (low_word_o),
    .high_word_o(high_word_o)
  );

  a_split_to_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    split_valid && advance |=> seg_valid)
    else $error("Stage two lost a transaction from stage one.");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(split_valid) && $stable(seg_valid))
    else $error("A stage moved while the pipeline was held.");

  a_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> low_word_o[31:0] == {fome_pkg::HdrPrice, fome_pkg::HdrExponent,
                                         fome_pkg::HdrTemplate, fome_pkg::HdrPmap})
    else $error("Message header bytes are wrong.");

  a_tail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> high_word_o[63:32] == 32'd0)
    else $error("Bytes beyond the longest message are not zero.");

endmodule
`default_nettype wire
